// ----- sv/cer_pkg.sv -----
// shared constants and the arctangent table for the covariance ellipse rotation
`default_nettype none
package cer_pkg;

  // fixed-point constants
  localparam logic [30:0] RAD_TO_TURN = 31'd683565276;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] Q30_ONE = 34'sd1073741824;
  localparam logic [40:0] LF_LIMIT = 41'h100_0000_0000;
  localparam logic [63:0] OUT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MAX = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [39:0] M2R_RESET = 40'd44180659;
  localparam int DIV_STEPS = 41;

  // arctangent of 2^-i as a fraction of one turn, 2^32 per turn
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    case (i)
      0: r = 32'd536870912;
      1: r = 32'd316933406;
      2: r = 32'd167458907;
      3: r = 32'd85004756;
      4: r = 32'd42667331;
      5: r = 32'd21354465;
      6: r = 32'd10679838;
      7: r = 32'd5340245;
      8: r = 32'd2670163;
      9: r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd3;
      29: r = 32'd1;
      30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/cer_cordic.sv -----
// pipelined cordic: cosine and sine in q.30 of a signed q4.28 angle
`default_nettype none
module cer_cordic #(
  parameter int STAGES = 24
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] rad,
  output logic signed [31:0]      cos_q30,
  output logic signed [31:0]      sin_q30
);

  logic signed [63:0] prod;
  logic signed [33:0] x [0:STAGES];
  logic signed [33:0] y [0:STAGES];
  logic signed [33:0] z [0:STAGES];
  logic               flip [0:STAGES];
  logic [31:0]        ang;
  logic [31:0]        ang_t;
  logic [31:0]        ang_f;
  logic signed [33:0] xf;
  logic signed [33:0] yf;

  // radians to binary angle
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= rad * $signed({1'b0, cer_pkg::RAD_TO_TURN});
    end
  end

  // quadrant fold into the right half plane
  always_comb begin
    ang   = prod[59:28];
    ang_t = ang + 32'h4000_0000;
    ang_f = ang_t[31] ? ang + 32'h8000_0000 : ang;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= cer_pkg::CORDIC_GAIN;
      y[0]    <= '0;
      z[0]    <= {{2{ang_f[31]}}, ang_f};
      flip[0] <= ang_t[31];
    end
  end

  // rotation stages
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [33:0] ATAN = $signed({2'b00, cer_pkg::atan_turn(i)});
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][33]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - ATAN;
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + ATAN;
        end
        flip[i+1] <= flip[i];
      end
    end
  end

  // undo the fold and clamp to unit magnitude
  always_comb begin
    xf = flip[STAGES] ? -x[STAGES] : x[STAGES];
    yf = flip[STAGES] ? -y[STAGES] : y[STAGES];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (xf > cer_pkg::Q30_ONE) begin
        cos_q30 <= 32'(cer_pkg::Q30_ONE);
      end else if (xf < -cer_pkg::Q30_ONE) begin
        cos_q30 <= 32'(-cer_pkg::Q30_ONE);
      end else begin
        cos_q30 <= xf[31:0];
      end
      if (yf > cer_pkg::Q30_ONE) begin
        sin_q30 <= 32'(cer_pkg::Q30_ONE);
      end else if (yf < -cer_pkg::Q30_ONE) begin
        sin_q30 <= 32'(-cer_pkg::Q30_ONE);
      end else begin
        sin_q30 <= yf[31:0];
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/covariance_ellipse_rotation.sv -----
// top level: rotates a sigma ellipse into longitude/latitude covariance
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid, in_ready, bearing, latitude,    | in
//           | sigma_cross, sigma_down                   |
//  result   | out_valid, out_ready, var_lon, var_lat,   | out
//           | cov_lon_lat, saturated                    |
//  config   | cfg_write, cfg_data (metres_to_radians)   | in
//
// one transfer per cycle sustained while the output is taken; the pipeline
// holds the cordic stages plus one stage per quotient bit of 1/cos(lat)
// reset clears the valid pipeline and loads the default metres_to_radians
// a stall at the output holds every stage; in_ready is low only while the
// output holds a result that has not been taken
`default_nettype none
module covariance_ellipse_rotation #(
  parameter int CORDIC_STAGES = 24
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [39:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] bearing,
  input  wire logic signed [29:0] latitude,
  input  wire logic [31:0]        sigma_cross,
  input  wire logic [31:0]        sigma_down,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [62:0]             var_lon,
  output logic [62:0]             var_lat,
  output logic signed [63:0]      cov_lon_lat,
  output logic                    saturated
);

  localparam int NDIV   = cer_pkg::DIV_STEPS;
  localparam int K_TRIG = CORDIC_STAGES + 3;
  localparam int K_DIV0 = K_TRIG + 1;
  localparam int K_R1   = K_DIV0 + NDIV + 1;
  localparam int LAST   = K_R1 + 8;
  localparam int VDLY   = CORDIC_STAGES;

  typedef struct packed {
    logic        sat;
    logic [63:0] val;
  } clamp_t;

  typedef struct packed {
    logic [63:0] vc;
    logic [63:0] vd;
    logic        sat;
  } var_t;

  typedef struct packed {
    logic [30:0] cos2;
    logic [30:0] sin2;
    logic [30:0] csm;
    logic [30:0] alc;
    logic [63:0] vc;
    logic [63:0] vd;
    logic [63:0] diff;
    logic        neg;
    logic        sat;
    logic        pole;
  } side_t;

  // right shift by 30 with saturation to a limit
  function automatic clamp_t shr30_clamp(input logic [127:0] v, input logic [63:0] lim);
    logic [97:0] sh;
    clamp_t      r;
    sh    = v[127:30];
    r.sat = (|sh[97:64]) || (sh[63:0] > lim);
    r.val = r.sat ? lim : sh[63:0];
    return r;
  endfunction

  // square of r40 >> 20 with saturation
  function automatic clamp_t var_fin(input logic [51:0] q2, input logic [51:0] q1,
                                     input logic [51:0] q0);
    logic [104:0] s;
    clamp_t       r;
    s     = {1'b0, q2, 52'd0} + {26'd0, q1, 27'd0} + {53'd0, q0};
    r.sat = |s[104:84];
    r.val = r.sat ? cer_pkg::ALL_ONES : s[83:20];
    return r;
  endfunction

  logic                en;
  logic [LAST:0]       vld;
  logic [39:0]         m2r;

  logic signed [31:0]  bear_r;
  logic signed [29:0]  lat_r;
  logic [31:0]         sc_r;
  logic [31:0]         sd_r;
  logic [51:0]         pc_lo, pc_hi, pd_lo, pd_hi;
  logic [51:0]         rc, rd;
  logic [51:0]         qc2, qc1, qc0, qd2, qd1, qd0;
  clamp_t              vc_f, vd_f;
  var_t                var_dly [0:VDLY-1];

  logic signed [31:0]  ca, sa, cl;
  logic [31:0]         ca_m, sa_m, cl_m;
  logic [61:0]         cc_p, ss_p, cs_p;
  logic [63:0]         vc_a, vd_a;

  logic [31:0]         dr [0:NDIV];
  logic [40:0]         dq [0:NDIV];
  side_t               side [0:NDIV];

  logic [40:0]         lf1, lf2, lf3, lf4, lf5;
  logic [62:0]         pl_c1, pl_c0, pl_d1, pl_d0;
  logic [62:0]         pb_c1, pb_c0, pb_d1, pb_d0;
  logic [62:0]         pm_1, pm_0;
  logic                neg1, neg2, neg3, neg4, neg5;
  logic                sat1, sat2, sat3, sat4, sat5, sat6;
  logic [96:0]         lat_sum, base_sum, m1_sum;
  clamp_t              lat_c, base_c, m1_c;
  logic [62:0]         vlat3, vlat4, vlat5, vlat6, vlat7;
  logic [63:0]         base3, m1_3;
  logic [51:0]         tb11, tb01, mb11, mb01;
  logic [52:0]         tb10, tb00, mb10, mb00;
  logic [104:0]        t1_sum, m2_sum;
  clamp_t              t1_c, m2_c;
  logic [63:0]         t1_5, cov5, cov6, cov7;
  logic [51:0]         lb11, lb01;
  logic [52:0]         lb10, lb00;
  logic [104:0]        lon_sum;
  clamp_t              lon_c;

  // global advance: every stage moves unless the output is held
  assign en        = ~vld[LAST] | out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:0], in_valid};
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      m2r <= cer_pkg::M2R_RESET;
    end else if (cfg_write) begin
      m2r <= cfg_data;
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (en) begin
      bear_r <= bearing;
      lat_r  <= latitude;
      sc_r   <= sigma_cross;
      sd_r   <= sigma_down;
    end
  end

  // trig pipelines
  cer_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_bear (
    .clk     (clk),
    .en      (en),
    .rad     (bear_r),
    .cos_q30 (ca),
    .sin_q30 (sa)
  );

  cer_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_lat (
    .clk     (clk),
    .en      (en),
    .rad     ({{2{lat_r[29]}}, lat_r}),
    .cos_q30 (cl),
    .sin_q30 ()
  );

  // variances: sigma times scale, then square
  assign vc_f = var_fin(qc2, qc1, qc0);
  assign vd_f = var_fin(qd2, qd1, qd0);

  always_ff @(posedge clk) begin
    if (en) begin
      pc_lo <= sc_r * m2r[19:0];
      pc_hi <= sc_r * m2r[39:20];
      pd_lo <= sd_r * m2r[19:0];
      pd_hi <= sd_r * m2r[39:20];
      rc    <= pc_hi + {20'd0, pc_lo[51:20]};
      rd    <= pd_hi + {20'd0, pd_lo[51:20]};
      qc2   <= rc[51:26] * rc[51:26];
      qc1   <= rc[51:26] * rc[25:0];
      qc0   <= rc[25:0] * rc[25:0];
      qd2   <= rd[51:26] * rd[51:26];
      qd1   <= rd[51:26] * rd[25:0];
      qd0   <= rd[25:0] * rd[25:0];
      var_dly[0] <= '{vc: vc_f.val, vd: vd_f.val, sat: vc_f.sat | vd_f.sat};
    end
  end

  // variance delay to meet the trig results
  for (genvar k = 1; k < VDLY; k++) begin : g_vdly
    always_ff @(posedge clk) begin
      if (en) begin
        var_dly[k] <= var_dly[k-1];
      end
    end
  end

  // rotation terms, pole check, difference and sign
  always_comb begin
    ca_m = ca[31] ? 32'd0 - ca : ca;
    sa_m = sa[31] ? 32'd0 - sa : sa;
    cl_m = cl[31] ? 32'd0 - cl : cl;
    cc_p = ca_m[30:0] * ca_m[30:0];
    ss_p = sa_m[30:0] * sa_m[30:0];
    cs_p = ca_m[30:0] * sa_m[30:0];
    vc_a = var_dly[VDLY-1].vc;
    vd_a = var_dly[VDLY-1].vd;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0].cos2 <= cc_p[60:30];
      side[0].sin2 <= ss_p[60:30];
      side[0].csm  <= cs_p[60:30];
      side[0].alc  <= cl_m[30:0];
      side[0].vc   <= vc_a;
      side[0].vd   <= vd_a;
      side[0].diff <= (vd_a >= vc_a) ? vd_a - vc_a : vc_a - vd_a;
      side[0].neg  <= (vd_a < vc_a) ^ (ca[31] ^ sa[31]) ^ cl[31];
      side[0].sat  <= var_dly[VDLY-1].sat | ~|cl_m[30:20];
      side[0].pole <= ~|cl_m[30:20];
      dr[0]        <= 32'd1 << 19;
      dq[0]        <= '0;
    end
  end

  // restoring divider for 2^60 / |cos(lat)|, one quotient bit per stage
  for (genvar j = 0; j < NDIV; j++) begin : g_div
    logic [31:0] r2;
    assign r2 = {dr[j][30:0], 1'b0};
    always_ff @(posedge clk) begin
      if (en) begin
        side[j+1] <= side[j];
        if (r2 >= {1'b0, side[j].alc}) begin
          dr[j+1] <= r2 - {1'b0, side[j].alc};
          dq[j+1] <= {dq[j][39:0], 1'b1};
        end else begin
          dr[j+1] <= r2;
          dq[j+1] <= {dq[j][39:0], 1'b0};
        end
      end
    end
  end

  // rotation partial products and the latitude factor
  always_ff @(posedge clk) begin
    if (en) begin
      lf1   <= side[NDIV].pole ? cer_pkg::LF_LIMIT : dq[NDIV];
      pl_c1 <= side[NDIV].vc[63:32] * side[NDIV].sin2;
      pl_c0 <= side[NDIV].vc[31:0] * side[NDIV].sin2;
      pl_d1 <= side[NDIV].vd[63:32] * side[NDIV].cos2;
      pl_d0 <= side[NDIV].vd[31:0] * side[NDIV].cos2;
      pb_c1 <= side[NDIV].vc[63:32] * side[NDIV].cos2;
      pb_c0 <= side[NDIV].vc[31:0] * side[NDIV].cos2;
      pb_d1 <= side[NDIV].vd[63:32] * side[NDIV].sin2;
      pb_d0 <= side[NDIV].vd[31:0] * side[NDIV].sin2;
      pm_1  <= side[NDIV].diff[63:32] * side[NDIV].csm;
      pm_0  <= side[NDIV].diff[31:0] * side[NDIV].csm;
      neg1  <= side[NDIV].neg;
      sat1  <= side[NDIV].sat;
    end
  end

  // rotation sums
  always_ff @(posedge clk) begin
    if (en) begin
      lat_sum  <= {2'd0, pl_c1, 32'd0} + {34'd0, pl_c0}
                + {2'd0, pl_d1, 32'd0} + {34'd0, pl_d0};
      base_sum <= {2'd0, pb_c1, 32'd0} + {34'd0, pb_c0}
                + {2'd0, pb_d1, 32'd0} + {34'd0, pb_d0};
      m1_sum   <= {2'd0, pm_1, 32'd0} + {34'd0, pm_0};
      lf2      <= lf1;
      neg2     <= neg1;
      sat2     <= sat1;
    end
  end

  // rotation clamps
  assign lat_c  = shr30_clamp({31'd0, lat_sum}, cer_pkg::OUT_MAX);
  assign base_c = shr30_clamp({31'd0, base_sum}, cer_pkg::ALL_ONES);
  assign m1_c   = shr30_clamp({31'd0, m1_sum}, cer_pkg::ALL_ONES);

  always_ff @(posedge clk) begin
    if (en) begin
      vlat3 <= lat_c.val[62:0];
      base3 <= base_c.val;
      m1_3  <= m1_c.val;
      lf3   <= lf2;
      neg3  <= neg2;
      sat3  <= sat2 | lat_c.sat | base_c.sat | m1_c.sat;
    end
  end

  // first scaling by the latitude factor: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      tb11  <= base3[63:32] * lf3[40:21];
      tb10  <= base3[63:32] * lf3[20:0];
      tb01  <= base3[31:0] * lf3[40:21];
      tb00  <= base3[31:0] * lf3[20:0];
      mb11  <= m1_3[63:32] * lf3[40:21];
      mb10  <= m1_3[63:32] * lf3[20:0];
      mb01  <= m1_3[31:0] * lf3[40:21];
      mb00  <= m1_3[31:0] * lf3[20:0];
      lf4   <= lf3;
      vlat4 <= vlat3;
      neg4  <= neg3;
      sat4  <= sat3;
    end
  end

  // first scaling: sums
  always_ff @(posedge clk) begin
    if (en) begin
      t1_sum <= {tb11, 53'd0} + {20'd0, tb10, 32'd0} + {32'd0, tb01, 21'd0} + {52'd0, tb00};
      m2_sum <= {mb11, 53'd0} + {20'd0, mb10, 32'd0} + {32'd0, mb01, 21'd0} + {52'd0, mb00};
      lf5    <= lf4;
      vlat5  <= vlat4;
      sat5   <= sat4;
      neg5   <= neg4;
    end
  end

  // first scaling: clamps, covariance sign
  assign t1_c = shr30_clamp({23'd0, t1_sum}, cer_pkg::ALL_ONES);
  assign m2_c = shr30_clamp({23'd0, m2_sum}, neg5 ? cer_pkg::NEG_MAX : cer_pkg::OUT_MAX);

  always_ff @(posedge clk) begin
    if (en) begin
      t1_5  <= t1_c.val;
      cov5  <= neg5 ? 64'd0 - m2_c.val : m2_c.val;
      vlat6 <= vlat5;
      sat6  <= sat5 | t1_c.sat | m2_c.sat;
    end
  end

  // second longitude scaling: partial products
  logic [40:0] lf6;
  logic        sat7;
  always_ff @(posedge clk) begin
    if (en) begin
      lb11  <= t1_5[63:32] * lf6[40:21];
      lb10  <= t1_5[63:32] * lf6[20:0];
      lb01  <= t1_5[31:0] * lf6[40:21];
      lb00  <= t1_5[31:0] * lf6[20:0];
      lf6   <= lf5;
      cov6  <= cov5;
      vlat7 <= vlat6;
      sat7  <= sat6;
    end
  end

  // second scaling: sum
  logic [62:0] vlat8;
  logic        sat8;
  always_ff @(posedge clk) begin
    if (en) begin
      lon_sum <= {lb11, 53'd0} + {20'd0, lb10, 32'd0} + {32'd0, lb01, 21'd0} + {52'd0, lb00};
      cov7    <= cov6;
      vlat8   <= vlat7;
      sat8    <= sat7;
    end
  end

  // output register
  assign lon_c = shr30_clamp({23'd0, lon_sum}, cer_pkg::OUT_MAX);

  always_ff @(posedge clk) begin
    if (en) begin
      var_lon     <= lon_c.val[62:0];
      var_lat     <= vlat8;
      cov_lon_lat <= cov7;
      saturated   <= sat8 | lon_c.sat;
    end
  end

  // a free output always lets a transfer in
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // a held output freezes the whole valid pipeline
  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> $stable(vld))
    else $error("pipeline moved during a stall");

  // away from the poles the latitude factor never exceeds its limit
  assert property (@(posedge clk) disable iff (rst)
    vld[K_DIV0 + NDIV] && !side[NDIV].pole |-> dq[NDIV] <= cer_pkg::LF_LIMIT)
    else $error("latitude factor out of range");

  // cordic cosines stay within unit magnitude
  assert property (@(posedge clk) disable iff (rst)
    vld[K_TRIG] |-> (ca_m <= 32'd1073741824) && (cl_m <= 32'd1073741824))
    else $error("cordic output beyond unit magnitude");

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// testbench for the covariance ellipse rotation block
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  localparam int STAGES = 24;
  localparam int LATENCY = STAGES + 55;
  localparam longint CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [62:0] lon;
    logic [62:0] lat;
    logic [63:0] cov;
    logic        sat;
  } cov_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [39:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] bearing = '0;
  logic signed [29:0] latitude = '0;
  logic [31:0] sigma_cross = '0;
  logic [31:0] sigma_down = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [62:0] var_lon;
  logic [62:0] var_lat;
  logic signed [63:0] cov_lon_lat;
  logic saturated;

  covariance_ellipse_rotation #(.CORDIC_STAGES(STAGES)) dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .bearing(bearing),
    .latitude(latitude), .sigma_cross(sigma_cross), .sigma_down(sigma_down),
    .out_valid(out_valid), .out_ready(out_ready), .var_lon(var_lon),
    .var_lat(var_lat), .cov_lon_lat(cov_lon_lat), .saturated(saturated)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  logic [39:0] m2r_scale;
  cov_result_t pending_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int sat_seen = 0;
  int stall_left = 0;
  longint cycles = 0;
  bit stall_enable = 1'b1;

  // pick a gap: mostly zero or short, sometimes long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic signed [63:0] floor_shr(logic signed [63:0] v, int k);
    return v >>> k;
  endfunction

  function automatic logic signed [63:0] unit_clamp(logic signed [63:0] v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  // cosine and sine in q.30 of a q4.28 angle
  task automatic trig(input logic signed [63:0] rad, output logic signed [63:0] c,
                      output logic signed [63:0] s);
    logic [63:0] prod;
    logic [31:0] a;
    logic flip;
    logic signed [63:0] x, y, z, nx;
    prod = rad * 64'sd683565276;
    a = prod[59:28];
    flip = a[31] ^ a[30];
    if (flip) a = a + 32'h8000_0000;
    z = {{32{a[31]}}, a};
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      if (z >= 0) begin
        nx = x - floor_shr(y, i);
        y = y + floor_shr(x, i);
        z = z - cer_pkg::atan_turn(i);
      end else begin
        nx = x + floor_shr(y, i);
        y = y - floor_shr(x, i);
        z = z + cer_pkg::atan_turn(i);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = unit_clamp(x);
    s = unit_clamp(y);
  endtask

  // wide value shifted right, clamped to a limit
  function automatic logic [63:0] shr_sat(logic [127:0] v, int sh, logic [63:0] lim,
                                          inout bit sat);
    logic [127:0] r;
    r = v >> sh;
    if (r > {64'd0, lim}) begin
      sat = 1'b1;
      return lim;
    end
    return r[63:0];
  endfunction

  function automatic logic [63:0] sigma_to_var(logic [31:0] sigma, inout bit sat);
    bit unused;
    logic [63:0] r40;
    unused = 1'b0;
    r40 = shr_sat({64'd0, sigma} * {88'd0, m2r_scale}, 20, cer_pkg::ALL_ONES, unused);
    return shr_sat({64'd0, r40} * {64'd0, r40}, 20, cer_pkg::ALL_ONES, sat);
  endfunction

  task automatic predict_covariance(input logic signed [31:0] brg,
                                    input logic signed [29:0] lat,
                                    input logic [31:0] sc, input logic [31:0] sd,
                                    output cov_result_t res);
    bit sat, neg;
    logic signed [63:0] ca, sa, cl, sl;
    logic [63:0] ac, as_m, cos2, sin2, csm, vc, vd, alc, lf, base, t1, diff, m1, m2;
    logic [63:0] lat_w, lon_w;
    sat = 1'b0;
    trig(64'(brg), ca, sa);
    trig(64'(lat), cl, sl);
    ac = ca < 0 ? -ca : ca;
    as_m = sa < 0 ? -sa : sa;
    cos2 = (ac * ac) >> 30;
    sin2 = (as_m * as_m) >> 30;
    csm = (ac * as_m) >> 30;
    vc = sigma_to_var(sc, sat);
    vd = sigma_to_var(sd, sat);
    alc = cl < 0 ? -cl : cl;
    // near a pole the latitude factor clamps
    if (alc < 64'd1048576) begin
      lf = 64'(cer_pkg::LF_LIMIT);
      sat = 1'b1;
    end else begin
      lf = (64'd1 << 60) / alc;
    end
    lat_w = shr_sat(128'(vc) * 128'(sin2) + 128'(vd) * 128'(cos2), 30,
                    cer_pkg::OUT_MAX, sat);
    res.lat = lat_w[62:0];
    base = shr_sat(128'(vc) * 128'(cos2) + 128'(vd) * 128'(sin2), 30,
                   cer_pkg::ALL_ONES, sat);
    t1 = shr_sat(128'(base) * 128'(lf), 30, cer_pkg::ALL_ONES, sat);
    lon_w = shr_sat(128'(t1) * 128'(lf), 30, cer_pkg::OUT_MAX, sat);
    res.lon = lon_w[62:0];
    diff = vd >= vc ? vd - vc : vc - vd;
    neg = (vd < vc) != ((ca < 0) != (sa < 0));
    neg = neg != (cl < 0);
    m1 = shr_sat(128'(diff) * 128'(csm), 30, cer_pkg::ALL_ONES, sat);
    m2 = shr_sat(128'(m1) * 128'(lf), 30, neg ? cer_pkg::NEG_MAX : cer_pkg::OUT_MAX, sat);
    res.cov = neg ? -m2 : m2;
    res.sat = sat;
  endtask

  // send one report, predicting its result on transfer
  task automatic send_report(input logic signed [31:0] brg, input logic signed [29:0] lat,
                             input logic [31:0] sc, input logic [31:0] sd);
    cov_result_t res;
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    predict_covariance(brg, lat, sc, sd, res);
    in_valid <= 1'b1;
    bearing <= brg;
    latitude <= lat;
    sigma_cross <= sc;
    sigma_down <= sd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(res);
    items_sent++;
  endtask

  // wait for the pipeline to empty, then load a new scale
  task automatic write_scale(input logic [39:0] val);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    m2r_scale = val;
  endtask

  function automatic logic signed [29:0] rand_latitude();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 30'($urandom);
    if (r == 1) return $urandom_range(0, 1) ? 30'sd421000000 : -30'sd421000000;
    return 30'($signed($urandom_range(0, 805306368)) - 402653184);
  endfunction

  function automatic logic [31:0] rand_sigma();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 32'h00FF_FFFF);
    if (r < 8) return $urandom_range(0, 32'h000F_FFFF);
    return $urandom;
  endfunction

  task automatic random_reports(input int n);
    for (int i = 0; i < n; i++)
      send_report($urandom, rand_latitude(), rand_sigma(), rand_sigma());
  endtask

  // directed: field extremes, poles, wrap, zero sigmas
  task automatic test_directed();
    send_report(0, 30'sd0, 0, 0);
    send_report(32'sh7FFF_FFFF, 30'sd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_report(32'sh8000_0000, 30'sd402653184, 32'd4096, 32'd8192);
    send_report(32'sd421657428, -30'sd402653184, 32'd40960, 32'd4096);
    send_report(32'sd210828714, 30'sd421657428, 32'd4096, 32'd40960);
    send_report(-32'sd210828714, -30'sd421657428, 32'd4096, 32'd4096);
    send_report(32'sd843314856, 30'sh1FFF_FFFF, 32'd100000, 32'd1);
    send_report(-32'sd843314856, 30'sh2000_0000, 32'd1, 32'd100000);
    send_report(32'sd1686629713, 30'sd421000000, 32'h0100_0000, 32'h0000_1000);
    send_report(32'sd12345678, 30'sd300000000, 32'hFFFF_FFFF, 0);
    send_report(32'sd99999999, -30'sd300000000, 0, 32'hFFFF_FFFF);
    send_report(32'h5555_5555, 30'h2AAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_report(32'hAAAA_AAAA, 30'h1555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
  endtask

  task automatic test_scale_settings();
    write_scale(40'd0);
    send_report(32'sd12345, 30'sd1000, 32'hFFFF_FFFF, 32'd77777);
    random_reports(40);
    write_scale(40'hFF_FFFF_FFFF);
    send_report(0, 30'sd0, 32'd1, 32'd2);
    random_reports(60);
    write_scale(40'd1);
    random_reports(40);
    write_scale({$urandom, 8'($urandom)});
    random_reports(60);
  endtask

  task automatic test_random_stream();
    write_scale(cer_pkg::M2R_RESET);
    random_reports(500);
    // back-to-back stretch with the output always ready
    stall_enable = 1'b0;
    for (int i = 0; i < 150; i++) begin
      in_valid <= 1'b1;
      bearing <= $urandom;
      latitude <= rand_latitude();
      sigma_cross <= rand_sigma();
      sigma_down <= rand_sigma();
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      begin
        cov_result_t res;
        predict_covariance(bearing, latitude, sigma_cross, sigma_down, res);
        pending_results.push_back(res);
        items_sent++;
      end
    end
    in_valid <= 1'b0;
    stall_enable = 1'b1;
  endtask

  // output side stalls: runs of low ready, mostly short
  always @(posedge clk) begin
    if (rst || !stall_enable) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
    end
  end

  // result checker
  always @(posedge clk) begin
    cov_result_t want;
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (saturated) sat_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer at cycle %0d", cycles);
      end else begin
        want = pending_results.pop_front();
        if (var_lon !== want.lon || var_lat !== want.lat || cov_lon_lat !== want.cov
            || saturated !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: lon %h/%h lat %h/%h cov %h/%h sat %b/%b (exp/got)",
                     want.lon, var_lon, want.lat, var_lat, want.cov, cov_lon_lat,
                     want.sat, saturated);
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    m2r_scale = cer_pkg::M2R_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_scale_settings();
    test_random_stream();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("sent %0d reports, checked %0d results, %0d saturated", items_sent,
             results_seen, sat_seen);
    $display("scales covered: zero, one, full range, default, random");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
